// ===== rtl/sobel_edge_magnitude_core_macros.svh =====
// Assertion macros shared by the Sobel edge magnitude RTL.
`ifndef SOBEL_EDGE_MAGNITUDE_CORE_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property that must hold on every clock edge out of reset
`define SEM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("sobel edge assertion failed");
// Condition implies another in the following cycle
`define SEM_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("sobel edge sequencing assertion failed");
`else
`define SEM_ASSERT(lbl, prop)
`define SEM_ASSERT_NEXT(lbl, cond, prop)
`endif
`endif

// ===== rtl/sem_pkg.sv =====
// Shared types and constants for the Sobel edge magnitude core.
`timescale 1ns / 1ps
package sem_pkg;
  localparam int MAX_WIDTH   = 1024;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = 16;
  localparam int LUMA_W      = 16;
  localparam int CFG_W       = 16;
  localparam int WIDTH_REG_W = 11;
  localparam int GRAD_W      = 18;
  localparam int ACC_W       = 37;

  // Register indexes
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // Luma weights (Q8)
  localparam logic [7:0] W_RED   = 8'd77;
  localparam logic [7:0] W_GREEN = 8'd150;
  localparam logic [7:0] W_BLUE  = 8'd29;

  typedef struct packed {
    logic       accept;
    logic       update;
    logic       grad;
    logic       sq_x;
    logic       sq_y;
    logic       root;
    logic [2:0] root_bit;
    logic       load_out;
  } sem_cmd_t;

  typedef struct packed {
    logic emit;
    logic out_free;
  } sem_sts_t;
endpackage

// ===== rtl/sem_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sem_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== rtl/sem_ctrl.sv =====
// Sequencer for the Sobel edge magnitude core.
`timescale 1ns / 1ps
`include "sobel_edge_magnitude_core_macros.svh"
module sem_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sem_pkg::sem_sts_t sts,
  output sem_pkg::sem_cmd_t cmd
);
  import sem_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_UPD, ST_GRAD, ST_SQX, ST_SQY, ST_ROOT, ST_OUT
  } state_t;

  state_t     state;
  logic [2:0] bit_cnt;

  // Hold state and root iteration count
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      bit_cnt <= 3'd7;
    end else begin
      unique case (state)
        ST_IDLE: if (in_valid) state <= ST_UPD;
        ST_UPD:  state <= sts.emit ? ST_GRAD : ST_IDLE;
        ST_GRAD: state <= ST_SQX;
        ST_SQX:  state <= ST_SQY;
        ST_SQY: begin
          state   <= ST_ROOT;
          bit_cnt <= 3'd7;
        end
        ST_ROOT: begin
          if (bit_cnt == 3'd0) state <= ST_OUT;
          else bit_cnt <= bit_cnt - 3'd1;
        end
        ST_OUT:  if (sts.out_free) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Decode commands from state
  assign in_ready     = (state == ST_IDLE);
  assign cmd.accept   = in_ready && in_valid;
  assign cmd.update   = (state == ST_UPD);
  assign cmd.grad     = (state == ST_GRAD);
  assign cmd.sq_x     = (state == ST_SQX);
  assign cmd.sq_y     = (state == ST_SQY);
  assign cmd.root     = (state == ST_ROOT);
  assign cmd.root_bit = bit_cnt;
  assign cmd.load_out = (state == ST_OUT) && sts.out_free;

  `SEM_ASSERT_NEXT(a_accept_to_update, cmd.accept, state == ST_UPD)
  `SEM_ASSERT_NEXT(a_root_ends, cmd.root && bit_cnt == 3'd0, state == ST_OUT)
  `SEM_ASSERT(a_load_only_free, !cmd.load_out || sts.out_free)
endmodule

// ===== rtl/sem_dpath.sv =====
// Datapath: luma, line stores, window, gradients, root and output register.
`timescale 1ns / 1ps
module sem_dpath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_index,
  input  logic [sem_pkg::CFG_W-1:0]      cfg_wr_data,
  input  logic [23:0]                    pix,
  input  sem_pkg::sem_cmd_t              cmd,
  output sem_pkg::sem_sts_t              sts,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [39:0]                    out_data,
  output logic                           out_last
);
  import sem_pkg::*;

  logic [WIDTH_REG_W-1:0] image_width;
  logic [ROW_W-1:0]       image_height;
  logic [WIDTH_REG_W-1:0] eff_w;
  logic [ROW_W-1:0]       eff_h;
  logic [COL_W-1:0]       col_cnt;
  logic [ROW_W-1:0]       row_cnt;
  logic [LUMA_W-1:0]      luma;
  logic [17:0]            luma_sum;
  logic [LUMA_W-1:0]      win [9];
  logic [LUMA_W-1:0]      older_q;
  logic [LUMA_W-1:0]      newer_q;
  logic                   col_end;
  logic                   row_end;
  logic [ROW_W-1:0]       res_row;
  logic [COL_W-1:0]       res_col;
  logic                   res_last;
  logic signed [GRAD_W:0] gx;
  logic signed [GRAD_W:0] gy;
  logic [GRAD_W-1:0]      ax;
  logic [GRAD_W-1:0]      ay;
  logic [GRAD_W-1:0]      sq_op;
  logic [2*GRAD_W-1:0]    sq_prod;
  logic [ACC_W-1:0]       acc;
  logic [15:0]            target;
  logic [7:0]             root;
  logic [7:0]             trial;
  logic [15:0]            trial_sq;

  // Take register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_REG_W'(640);
      image_height <= ROW_W'(480);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_wr_data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Clamp frame size
  always_comb begin
    eff_w = image_width;
    if (image_width < WIDTH_REG_W'(3)) eff_w = WIDTH_REG_W'(3);
    if (image_width > WIDTH_REG_W'(MAX_WIDTH)) eff_w = WIDTH_REG_W'(MAX_WIDTH);
    eff_h = (image_height < ROW_W'(3)) ? ROW_W'(3) : image_height;
  end

  assign col_end = ({1'b0, col_cnt} + WIDTH_REG_W'(1)) >= eff_w;
  assign row_end = ({1'b0, row_cnt} + 17'd1) >= {1'b0, eff_h};

  assign luma_sum = 18'(pix[7:0]) * 18'(W_RED) + 18'(pix[15:8]) * 18'(W_GREEN)
                  + 18'(pix[23:16]) * 18'(W_BLUE);

  // Latch luma of the accepted pixel
  always_ff @(posedge clk) begin
    if (cmd.accept) luma <= luma_sum[LUMA_W-1:0];
  end

  sem_ram #(.WIDTH(LUMA_W), .DEPTH(MAX_WIDTH)) u_older (
    .clk(clk), .we(cmd.update), .waddr(col_cnt), .wdata(newer_q),
    .re(cmd.accept), .raddr(col_cnt), .rdata(older_q)
  );
  sem_ram #(.WIDTH(LUMA_W), .DEPTH(MAX_WIDTH)) u_newer (
    .clk(clk), .we(cmd.update), .waddr(col_cnt), .wdata(luma),
    .re(cmd.accept), .raddr(col_cnt), .rdata(newer_q)
  );

  assign sts.emit = (row_cnt >= ROW_W'(2)) && (col_cnt >= COL_W'(2));

  // Shift window, advance position, capture result position
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
      for (int i = 0; i < 9; i++) win[i] <= '0;
    end else if (cmd.update) begin
      for (int k = 0; k < 3; k++) begin
        win[k*3]   <= win[k*3+1];
        win[k*3+1] <= win[k*3+2];
      end
      win[2] <= older_q;
      win[5] <= newer_q;
      win[8] <= luma;
      if (col_end) begin
        col_cnt <= '0;
        row_cnt <= row_end ? '0 : row_cnt + ROW_W'(1);
      end else begin
        col_cnt <= col_cnt + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      res_row  <= row_cnt - ROW_W'(1);
      res_col  <= col_cnt - COL_W'(1);
      res_last <= row_end && col_end;
    end
  end

  // Sobel gradients
  assign gx = $signed({1'b0, 18'(win[6]) + 18'({win[7], 1'b0}) + 18'(win[8])})
            - $signed({1'b0, 18'(win[0]) + 18'({win[1], 1'b0}) + 18'(win[2])});
  assign gy = $signed({1'b0, 18'(win[2]) + 18'({win[5], 1'b0}) + 18'(win[8])})
            - $signed({1'b0, 18'(win[0]) + 18'({win[3], 1'b0}) + 18'(win[6])});

  always_ff @(posedge clk) begin
    if (cmd.grad) begin
      ax <= gx[GRAD_W] ? GRAD_W'(-gx) : gx[GRAD_W-1:0];
      ay <= gy[GRAD_W] ? GRAD_W'(-gy) : gy[GRAD_W-1:0];
    end
  end

  // Sum of squares through one shared multiplier
  assign sq_op   = cmd.sq_y ? ay : ax;
  assign sq_prod = (2*GRAD_W)'(sq_op) * (2*GRAD_W)'(sq_op);
  always_ff @(posedge clk) begin
    if (cmd.sq_x) acc <= ACC_W'(sq_prod);
    else if (cmd.sq_y) acc <= acc + ACC_W'(sq_prod);
  end

  // Root of the Q16-dropped sum, one result bit per step, saturating at 255
  assign target   = (acc[ACC_W-1:32] != '0) ? 16'hFFFF : acc[31:16];
  assign trial    = root | (8'd1 << cmd.root_bit);
  assign trial_sq = 16'(trial) * 16'(trial);

  always_ff @(posedge clk) begin
    if (cmd.sq_y) root <= '0;
    else if (cmd.root && trial_sq <= target) root <= trial;
  end

  // Output register
  assign sts.out_free = !out_valid;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= {6'd0, res_col, res_row, root};
      out_last <= res_last;
    end
  end
endmodule

// ===== rtl/sobel_edge_magnitude_core.sv =====
// Top level of the Sobel 3x3 edge magnitude core.
//
// Pixels enter on the s_axis channel in raster order, one RGB pixel per
// transaction. For every interior centre pixel one result leaves on the
// m_axis channel: the gradient magnitude with the centre's row and column;
// tlast marks the final interior result of the frame. Border pixels give no
// result. Frame size is set through the write port (index 0 width, index 1
// height) while the block is idle; reset restores 640 x 480 and puts the
// position counters at the frame origin. The line stores need no clearing.
// A pixel that completes no window passes through the window update only;
// a pixel that completes one passes through the window update, the gradients,
// the squaring of each gradient in turn on the shared multiplier, the square
// root at one result bit per cycle and the load of the output register. A
// new pixel is taken only when the last one is through. The result waits
// in an output register; a stalled receiver holds it there, and the next
// window result then waits until that register has been taken.
`timescale 1ns / 1ps
module sobel_edge_magnitude_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_index,
  input  logic [sem_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [23:0]               s_axis_tdata,  // red, green, blue
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [39:0]               m_axis_tdata,  // edge_value, centre_row, centre_col
  output logic                      m_axis_tlast
);
  import sem_pkg::*;

  sem_cmd_t cmd;
  sem_sts_t sts;

  sem_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .sts(sts), .cmd(cmd)
  );

  sem_dpath u_dpath (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_wr_data(cfg_wr_data), .pix(s_axis_tdata), .cmd(cmd), .sts(sts),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_data(m_axis_tdata), .out_last(m_axis_tlast)
  );
endmodule
